// ===== rtl/multi_timer_bank_macros.svh =====
// Assertion macros for the multi-timer bank.
// Included by files that carry concurrent checks; expects clk and rst in scope.
`ifndef MULTI_TIMER_BANK_MACROS_SVH
`define MULTI_TIMER_BANK_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define MTB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MTB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define MTB_ASSERT_NOW(lbl, ante, cons, msg)
`define MTB_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/mtb_pkg.sv =====
// Package for the multi-timer bank: beat types, operation codes, FSM states,
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps

package mtb_pkg;

  localparam int DEF_NUM_TIMERS = 8;
  localparam int CNT_W          = 16;
  localparam int OP_W           = 3;
  localparam int ID_W           = 8;

  // a delay start of one tick is stretched to this
  localparam logic [CNT_W-1:0] DELAY_MIN = 16'd2;

  localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
  localparam logic [OP_W-1:0] OP_START = 3'd1;
  localparam logic [OP_W-1:0] OP_STOP  = 3'd2;
  localparam logic [OP_W-1:0] OP_CHECK = 3'd3;
  localparam logic [OP_W-1:0] OP_DELAY = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [ID_W-1:0]  timer_id;
    logic [CNT_W-1:0] period;
    logic             auto_reload;
  } cmd_t;

  typedef struct packed {
    logic expired;
    logic delay_done;
    logic bad_id;
  } rsp_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] reload;
    logic             flag;
    logic             auto_rl;
  } tmr_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SWEEP,
    S_WAIT,
    S_RESULT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic cap;       // latch the command beat
    logic rd_en;     // read a timer entry, write it back next cycle
    logic rd_sweep;  // read address from sweep counter, else from timer_id
    logic cnt_inc;
    logic dly_tick;
    logic dly_load;
    logic rsp_load;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            bad;
    logic            cnt_last;
  } sts_t;

endpackage

// ===== rtl/multi_timer_bank.sv =====
// Top level of the multi-timer bank: controller plus datapath, and checks.
// Depends on mtb_pkg, mtb_ctrl, mtb_dp and multi_timer_bank_macros.svh.
//
//   channel   beat     handshake             payload
//   command   cmd      cmd_valid/cmd_stall   mtb_pkg::cmd_t
//   result    rsp      rsp_valid/rsp_stall   mtb_pkg::rsp_t
//
// A tick sweeps the timer RAM one entry a cycle (read, then write-back in the
// cycle after). Start, stop and check pass through decode, wait and result;
// delay start and bad ids through decode and result. Reset clears the entry
// valid bits at once, so no clearing pass follows it. One command at a time;
// a command is taken while the previous result still waits, and holds in the
// result state until the result register is free.
`timescale 1ns / 1ps
`include "multi_timer_bank_macros.svh"

module multi_timer_bank #(
  parameter int NUM_TIMERS = mtb_pkg::DEF_NUM_TIMERS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  mtb_pkg::cmd_t cmd,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output mtb_pkg::rsp_t rsp
);
  import mtb_pkg::*;

  ctl_t ctl;
  sts_t sts;

  mtb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  mtb_dp #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .ctl (ctl),
    .sts (sts),
    .rsp (rsp)
  );

  // an accepted beat keeps the port busy for at least the decode cycle
  `MTB_ASSERT_NEXT(a_busy_after_accept, cmd_valid && !cmd_stall, cmd_stall, "accept not followed by busy")
  // no RAM traffic while the command port is open
  `MTB_ASSERT_NOW(a_no_rd_idle, !cmd_stall, !ctl.rd_en && !ctl.dly_tick, "RAM access while idle")
  // a bad id never reports an expiry
  `MTB_ASSERT_NOW(a_bad_no_exp, rsp_valid, !(rsp.bad_id && rsp.expired), "expired with bad id")
  // result loaded only when the output register is free
  `MTB_ASSERT_NOW(a_no_overwrite, ctl.rsp_load, !rsp_valid || !rsp_stall, "result overwritten")

endmodule

// ===== rtl/mtb_dp.sv =====
// Datapath of the multi-timer bank: command latch, timer RAM with valid bits,
// sweep counter, delay counter and result register. Depends on mtb_pkg.
`timescale 1ns / 1ps

module mtb_dp #(
  parameter int NUM_TIMERS = mtb_pkg::DEF_NUM_TIMERS
) (
  input  logic          clk,
  input  logic          rst,
  input  mtb_pkg::cmd_t cmd,
  input  mtb_pkg::ctl_t ctl,
  output mtb_pkg::sts_t sts,
  output mtb_pkg::rsp_t rsp
);
  import mtb_pkg::*;

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);
  localparam logic [ID_W-1:0]  ID_LIMIT = ID_W'(NUM_TIMERS);

  function automatic tmr_t apply_op(input logic [OP_W-1:0] op, input tmr_t ent,
                                    input logic [CNT_W-1:0] per, input logic mode);
    tmr_t r;
    r = ent;
    case (op)
      OP_TICK: begin
        if (ent.count != '0) begin
          r.count = ent.count - 16'd1;
          if (ent.count == 16'd1) begin
            r.flag = 1'b1;
            if (ent.auto_rl) r.count = ent.reload;
          end
        end
      end
      OP_START: begin
        r.count   = per;
        r.reload  = per;
        r.flag    = 1'b0;
        r.auto_rl = mode;
      end
      OP_STOP: begin
        r.count   = '0;
        r.flag    = 1'b0;
        r.auto_rl = 1'b0;
      end
      OP_CHECK: r.flag = 1'b0;
      default:  r = ent;
    endcase
    return r;
  endfunction

  cmd_t               item;
  logic [IDX_W-1:0]   cnt;
  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   wb_addr;
  logic               pend;
  tmr_t               rd_q;
  logic               rd_vld;
  tmr_t               ent;
  tmr_t               wb_ent;
  tmr_t               mem [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] vld;
  logic               exp_hit;
  logic [CNT_W-1:0]   dly_rem;
  logic               dly_exp;
  logic               uses_id;
  rsp_t               rsp_q;

  always_ff @(posedge clk) begin
    if (ctl.cap) item <= cmd;
  end

  assign uses_id = (item.operation == OP_START) || (item.operation == OP_STOP) ||
                   (item.operation == OP_CHECK);

  assign sts.op       = item.operation;
  assign sts.bad      = uses_id && (item.timer_id >= ID_LIMIT);
  assign sts.cnt_last = (cnt == LAST_IDX);

  always_ff @(posedge clk) begin
    if (rst || ctl.cap) begin
      cnt <= '0;
    end else if (ctl.cnt_inc) begin
      cnt <= cnt + 1'b1;
    end
  end

  assign rd_addr = ctl.rd_sweep ? cnt : item.timer_id[IDX_W-1:0];

  // read stage
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_q    <= mem[rd_addr];
      rd_vld  <= vld[rd_addr];
      wb_addr <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= ctl.rd_en;
    end
  end

  // never-written entries read as the reset value
  assign ent    = rd_vld ? rd_q : '0;
  assign wb_ent = apply_op(item.operation, ent, item.period, item.auto_reload);

  // write-back stage
  always_ff @(posedge clk) begin
    if (pend) mem[wb_addr] <= wb_ent;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (pend) begin
      vld[wb_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cap) begin
      exp_hit <= 1'b0;
    end else if (pend && (item.operation == OP_CHECK) && ent.flag) begin
      exp_hit <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dly_rem <= '0;
      dly_exp <= 1'b0;
    end else if (ctl.dly_tick) begin
      if (dly_rem != '0) begin
        dly_rem <= dly_rem - 16'd1;
        if (dly_rem == 16'd1) dly_exp <= 1'b1;
      end
    end else if (ctl.dly_load && (item.period != '0)) begin
      dly_rem <= (item.period == 16'd1) ? DELAY_MIN : item.period;
      dly_exp <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rsp_load) begin
      rsp_q.expired    <= exp_hit;
      rsp_q.delay_done <= dly_exp;
      rsp_q.bad_id     <= sts.bad;
    end
  end

  assign rsp = rsp_q;

endmodule

// ===== rtl/mtb_ctrl.sv =====
// Controller of the multi-timer bank: sequences decode, RAM sweep/update and
// the result beat. Depends on mtb_pkg.
`timescale 1ns / 1ps

module mtb_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  input  mtb_pkg::sts_t sts,
  output mtb_pkg::ctl_t ctl
);
  import mtb_pkg::*;

  state_t state;
  state_t state_next;
  logic   rsp_free;
  logic   is_id_op;

  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign is_id_op  = (sts.op == OP_START) || (sts.op == OP_STOP) || (sts.op == OP_CHECK);
  assign cmd_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        if (sts.op == OP_TICK) begin
          state_next = sts.cnt_last ? S_WAIT : S_SWEEP;
        end else if (is_id_op && !sts.bad) begin
          state_next = S_WAIT;
        end else begin
          state_next = S_RESULT;
        end
      end
      S_SWEEP: begin
        if (sts.cnt_last) state_next = S_WAIT;
      end
      S_WAIT:   state_next = S_RESULT;
      S_RESULT: begin
        if (rsp_free) state_next = S_IDLE;
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    unique case (state)
      S_IDLE:   ctl.cap = cmd_valid;
      S_DECODE: begin
        if (sts.op == OP_TICK) begin
          ctl.dly_tick = 1'b1;
          ctl.rd_en    = 1'b1;
          ctl.rd_sweep = 1'b1;
          ctl.cnt_inc  = 1'b1;
        end else if (is_id_op && !sts.bad) begin
          ctl.rd_en    = 1'b1;
        end else if (sts.op == OP_DELAY) begin
          ctl.dly_load = 1'b1;
        end
      end
      S_SWEEP: begin
        ctl.rd_en    = 1'b1;
        ctl.rd_sweep = 1'b1;
        ctl.cnt_inc  = 1'b1;
      end
      S_WAIT:   ctl = '0;
      S_RESULT: ctl.rsp_load = rsp_free;
      default:  ctl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule
